// ----- sv/kpi_pkg.sv -----
package kpi_pkg;

    localparam int NCOMP      = 15;
    localparam int COMP_W     = 4;
    localparam int VALUE_W    = 32;
    localparam int KEYFRAME_W = 16;
    localparam int OP_W       = 3;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = 40;
    localparam int QUO_W      = 32;
    localparam int DCNT_W     = 5;

    typedef enum logic [OP_W-1:0] {
        OP_STAGE  = 3'd0,
        OP_APPEND = 3'd1,
        OP_TICK   = 3'd2,
        OP_SAMPLE = 3'd3,
        OP_CLEAR  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        MODE_ZERO   = 2'd0,
        MODE_HOLD   = 2'd1,
        MODE_INTERP = 2'd2
    } mode_t;

    typedef struct packed {
        logic latch_item;
        logic stage_wr;
        logic full_set;
        logic frame_wr;
        logic copy_wr;
        logic count_inc;
        logic frame_sel_next;
        logic val_sel_next;
        logic tick_upd;
        logic clear_tbl;
        logic fa_latch;
        logic mode_latch;
        logic comp_clr;
        logic comp_inc;
        logic a_latch;
        logic b_latch;
        logic mul;
        logic div_init;
        logic div_step;
        logic out_plain;
        logic out_sample;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic comp_last;
        logic div_done;
        logic interp;
        logic out_free;
    } stat_t;

endpackage

// ----- sv/kpi_ctrl.sv -----
module kpi_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  kpi_pkg::stat_t  stat,
    output kpi_pkg::cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_COPY, ST_TICK_DO, ST_SA_FA, ST_SA_FB,
        ST_C_RDA, ST_C_LA, ST_C_LB, ST_C_MUL, ST_C_DINIT, ST_C_DIV,
        ST_EMIT, ST_RESULT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_item = 1'b1;
                    state_next     = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (stat.op)
                    kpi_pkg::OP_STAGE: begin
                        cmd.stage_wr = 1'b1;
                        state_next   = ST_RESULT;
                    end
                    kpi_pkg::OP_APPEND: begin
                        if (stat.full) begin
                            cmd.full_set = 1'b1;
                            state_next   = ST_RESULT;
                        end else begin
                            cmd.frame_wr = 1'b1;
                            cmd.comp_clr = 1'b1;
                            state_next   = ST_COPY;
                        end
                    end
                    kpi_pkg::OP_TICK: begin
                        cmd.frame_sel_next = 1'b1;
                        state_next         = ST_TICK_DO;
                    end
                    kpi_pkg::OP_SAMPLE: begin
                        state_next = ST_SA_FA;
                    end
                    kpi_pkg::OP_CLEAR: begin
                        cmd.clear_tbl = 1'b1;
                        state_next    = ST_RESULT;
                    end
                    default: begin
                        state_next = ST_RESULT;
                    end
                endcase
            end
            ST_COPY: begin
                cmd.copy_wr  = 1'b1;
                cmd.comp_inc = 1'b1;
                if (stat.comp_last) begin
                    cmd.count_inc = 1'b1;
                    state_next    = ST_RESULT;
                end
            end
            ST_TICK_DO: begin
                cmd.tick_upd = 1'b1;
                state_next   = ST_RESULT;
            end
            ST_SA_FA: begin
                cmd.fa_latch       = 1'b1;
                cmd.frame_sel_next = 1'b1;
                state_next         = ST_SA_FB;
            end
            ST_SA_FB: begin
                cmd.mode_latch = 1'b1;
                cmd.comp_clr   = 1'b1;
                state_next     = ST_C_RDA;
            end
            ST_C_RDA: begin
                state_next = ST_C_LA;
            end
            ST_C_LA: begin
                cmd.a_latch      = 1'b1;
                cmd.val_sel_next = 1'b1;
                state_next       = ST_C_LB;
            end
            ST_C_LB: begin
                cmd.b_latch = 1'b1;
                state_next  = stat.interp ? ST_C_MUL : ST_EMIT;
            end
            ST_C_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_C_DINIT;
            end
            ST_C_DINIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_C_DIV;
            end
            ST_C_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.out_sample = 1'b1;
                    if (stat.comp_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.comp_inc = 1'b1;
                        state_next   = ST_C_RDA;
                    end
                end
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_plain = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/kpi_dp.sv -----
module kpi_dp #(
    parameter int MAX_KEYS   = 64,
    parameter int FRAME_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [kpi_pkg::OP_W-1:0]        s_tuser,
    input  logic [kpi_pkg::S_TDATA_W-1:0]   s_tdata,
    input  kpi_pkg::cmd_t                   cmd,
    output kpi_pkg::stat_t                  stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [kpi_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    output logic [1:0]                      m_tuser
);

    localparam int KB     = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW     = KB + 1;
    localparam int VDEPTH = MAX_KEYS * kpi_pkg::NCOMP;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int FB     = FRAME_BITS;
    localparam int VW     = kpi_pkg::VALUE_W;
    localparam int QW     = kpi_pkg::QUO_W;
    localparam int PW     = QW + FB;

    // Item fields.
    kpi_pkg::op_t                op_reg;
    logic [kpi_pkg::COMP_W-1:0]  idx_reg;
    logic [VW-1:0]               val_reg;
    logic [FB-1:0]               frm_reg;

    logic [VW-1:0]               staged_reg [kpi_pkg::NCOMP];
    logic [FB-1:0]               key_frames [MAX_KEYS];
    logic [VW-1:0]               key_values [VDEPTH];

    logic [CW-1:0]               count_reg;
    logic [KB-1:0]               ck_reg;
    logic [FB-1:0]               cf_reg;

    logic [FB-1:0]               frame_rd_reg;
    logic [VW-1:0]               val_rd_reg;

    logic [FB-1:0]               fa_reg, span_reg, el_reg;
    kpi_pkg::mode_t              mode_reg;
    logic [kpi_pkg::COMP_W-1:0]  comp_reg;
    logic [VW-1:0]               a_reg, b_reg;
    logic                        neg_reg;
    logic [PW-1:0]               prod_reg;
    logic [FB-1:0]               rem_reg;
    logic [QW-1:0]               quo_reg;
    logic [kpi_pkg::DCNT_W-1:0]  dcnt_reg;
    logic                        done_flag_reg, full_flag_reg;

    logic                        m_tvalid_reg;
    logic [kpi_pkg::COMP_W-1:0]  out_index_reg;
    logic [VW-1:0]               out_value_reg;
    logic                        out_last_reg, out_done_reg, out_full_reg;

    logic [31:0]                 kf_wide;
    logic [CW-1:0]               ck_ext, ck1;
    logic [KB-1:0]               frame_raddr;
    logic [VAW-1:0]              cur_base, val_raddr, wr_addr;
    logic [FB-1:0]               fb_w, span_w, el_raw, el_w, cf_inc;
    logic                        zero_w, hold_w;
    logic [VW:0]                 diff_w;
    logic [VW-1:0]               mag_w;
    logic [FB:0]                 trial_w;
    logic                        ge_w;
    logic [VW-1:0]               sample_w;

    assign kf_wide = 32'(s_tdata[51:36]);
    assign ck_ext  = CW'(ck_reg);
    assign ck1     = ck_ext + CW'(1);

    assign frame_raddr = cmd.frame_sel_next ? KB'(ck1) : ck_reg;
    // Key base address is key * 15, formed as key * 16 - key.
    assign cur_base  = (VAW'(ck_reg) << 4) - VAW'(ck_reg);
    assign val_raddr = cur_base + VAW'(comp_reg)
                     + (cmd.val_sel_next ? VAW'(kpi_pkg::NCOMP) : VAW'(0));
    assign wr_addr   = (VAW'(count_reg[KB-1:0]) << 4) - VAW'(count_reg[KB-1:0])
                     + VAW'(comp_reg);

    assign fb_w   = frame_rd_reg;
    assign span_w = fb_w - fa_reg;
    assign el_raw = cf_reg - fa_reg;
    assign el_w   = (cf_reg < fa_reg) ? '0 : ((el_raw > span_w) ? span_w : el_raw);
    assign zero_w = (count_reg == '0) || (ck_ext >= count_reg);
    assign hold_w = (fa_reg == cf_reg) || (ck1 >= count_reg) || (fb_w <= fa_reg);
    assign cf_inc = cf_reg + FB'(1);

    assign diff_w = {b_reg[VW-1], b_reg} - {a_reg[VW-1], a_reg};
    assign mag_w  = diff_w[VW] ? VW'(-diff_w) : diff_w[VW-1:0];

    // One quotient bit per cycle; the quotient never exceeds the magnitude.
    assign trial_w = {rem_reg, quo_reg[QW-1]};
    assign ge_w    = (trial_w >= {1'b0, span_reg});

    always_comb begin
        case (mode_reg)
            kpi_pkg::MODE_HOLD:   sample_w = a_reg;
            kpi_pkg::MODE_INTERP: sample_w = neg_reg ? (a_reg - quo_reg) : (a_reg + quo_reg);
            default:              sample_w = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.frame_wr) begin
            key_frames[count_reg[KB-1:0]] <= frm_reg;
        end
        frame_rd_reg <= key_frames[frame_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.copy_wr) begin
            key_values[wr_addr] <= staged_reg[comp_reg];
        end
        val_rd_reg <= key_values[val_raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            op_reg  <= kpi_pkg::op_t'(s_tuser);
            idx_reg <= s_tdata[3:0];
            val_reg <= s_tdata[35:4];
            frm_reg <= kf_wide[FB-1:0];
        end
        if (cmd.fa_latch) begin
            fa_reg <= frame_rd_reg;
        end
        if (cmd.mode_latch) begin
            span_reg <= span_w;
            el_reg   <= el_w;
            if (zero_w) begin
                mode_reg <= kpi_pkg::MODE_ZERO;
            end else if (hold_w) begin
                mode_reg <= kpi_pkg::MODE_HOLD;
            end else begin
                mode_reg <= kpi_pkg::MODE_INTERP;
            end
        end
        if (cmd.a_latch) begin
            a_reg <= val_rd_reg;
        end
        if (cmd.b_latch) begin
            b_reg <= val_rd_reg;
        end
        if (cmd.mul) begin
            neg_reg  <= diff_w[VW];
            prod_reg <= PW'(mag_w) * PW'(el_reg);
        end
        if (cmd.div_init) begin
            rem_reg  <= prod_reg[PW-1:QW];
            quo_reg  <= prod_reg[QW-1:0];
            dcnt_reg <= '1;
        end else if (cmd.div_step) begin
            rem_reg  <= ge_w ? FB'(trial_w - {1'b0, span_reg}) : trial_w[FB-1:0];
            quo_reg  <= {quo_reg[QW-2:0], ge_w};
            dcnt_reg <= dcnt_reg - 1'b1;
        end
        if (cmd.out_sample) begin
            out_index_reg <= comp_reg;
            out_value_reg <= sample_w;
            out_last_reg  <= (comp_reg == kpi_pkg::COMP_W'(kpi_pkg::NCOMP - 1));
            out_done_reg  <= 1'b0;
            out_full_reg  <= 1'b0;
        end else if (cmd.out_plain) begin
            out_index_reg <= '0;
            out_value_reg <= '0;
            out_last_reg  <= 1'b1;
            out_done_reg  <= done_flag_reg;
            out_full_reg  <= full_flag_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < kpi_pkg::NCOMP; i++) begin
                staged_reg[i] <= '0;
            end
            count_reg     <= '0;
            ck_reg        <= '0;
            cf_reg        <= '0;
            comp_reg      <= '0;
            done_flag_reg <= 1'b0;
            full_flag_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cmd.stage_wr && (idx_reg < kpi_pkg::COMP_W'(kpi_pkg::NCOMP))) begin
                staged_reg[idx_reg] <= val_reg;
            end
            if (cmd.latch_item) begin
                done_flag_reg <= 1'b0;
                full_flag_reg <= 1'b0;
            end
            if (cmd.full_set) begin
                full_flag_reg <= 1'b1;
            end
            if (cmd.comp_clr) begin
                comp_reg <= '0;
            end else if (cmd.comp_inc) begin
                comp_reg <= comp_reg + 1'b1;
            end
            if (cmd.count_inc) begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.clear_tbl) begin
                count_reg <= '0;
                ck_reg    <= '0;
                cf_reg    <= '0;
            end
            if (cmd.tick_upd) begin
                if ((count_reg != '0) && (ck1 < count_reg)) begin
                    cf_reg <= cf_inc;
                    if (cf_inc >= frame_rd_reg) begin
                        ck_reg <= ck_reg + 1'b1;
                    end
                end else begin
                    count_reg     <= '0;
                    ck_reg        <= '0;
                    cf_reg        <= '0;
                    done_flag_reg <= 1'b1;
                end
            end
            if (cmd.out_sample || cmd.out_plain) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign stat.op        = op_reg;
    assign stat.full      = (count_reg == CW'(MAX_KEYS));
    assign stat.comp_last = (comp_reg == kpi_pkg::COMP_W'(kpi_pkg::NCOMP - 1));
    assign stat.div_done  = (dcnt_reg == '0);
    assign stat.interp    = (mode_reg == kpi_pkg::MODE_INTERP);
    assign stat.out_free  = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = {out_full_reg, out_done_reg};

endmodule

// ----- sv/keyframe_pose_interpolator.sv -----
// Channel   Ports              Contents
// input     s_tvalid/s_tready  s_tuser: operation; s_tdata: index, value, key frame
// result    m_tvalid/m_tready  m_tdata: out_index, out_value; m_tlast; m_tuser: flags
//
// One item is worked at a time. Append copies the staged key into the value memory
// one component at a time. A blending sample passes each component through the
// restoring divider, which forms one quotient bit a cycle.
// Reset is synchronous; the key memories hold no reset value.
// A stalled result holds the sequencer in its emit or result step.
module keyframe_pose_interpolator #(
    parameter int MAX_KEYS   = 64,
    parameter int FRAME_BITS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // fields from bit 0: component_index[3:0], component_value[35:4],
    // key_frame[51:36]
    input  logic [kpi_pkg::S_TDATA_W-1:0]   s_tdata,
    // fields from bit 0: operation[2:0]
    input  logic [kpi_pkg::OP_W-1:0]        s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // fields from bit 0: out_index[3:0], out_value[35:4]
    output logic [kpi_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    // fields from bit 0: anim_done[0], table_full[1]
    output logic [1:0]                      m_tuser
);

    kpi_pkg::cmd_t  cmd;
    kpi_pkg::stat_t stat;

    kpi_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kpi_dp #(
        .MAX_KEYS   (MAX_KEYS),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ----- tb/tb.sv -----
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXK = 64;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [kpi_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic [kpi_pkg::OP_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [kpi_pkg::M_TDATA_W-1:0] m_tdata;
    logic m_tlast;
    logic [1:0] m_tuser;

    keyframe_pose_interpolator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    typedef struct packed {
        logic [3:0]  idx;
        logic [31:0] value;
        logic        last;
        logic        done;
        logic        full;
    } pose_out_t;

    pose_out_t pose_q[$];
    int errors = 0;
    int send_idle = 0;
    int recv_idle = 0;
    int items_sent = 0;

    // Model of the key table.
    logic [15:0] frames_m [MAXK];
    logic [31:0] values_m [MAXK][kpi_pkg::NCOMP];
    logic [31:0] staged_m [kpi_pkg::NCOMP];
    int unsigned nkeys, cur_key;
    logic [15:0] cur_frame;

    function automatic logic [31:0] blend_component(int c);
        longint a, b, span, el, mag, q;
        if (nkeys == 0 || cur_key >= nkeys) return 0;
        a = longint'($signed(values_m[cur_key][c]));
        if (frames_m[cur_key] == cur_frame) return a[31:0];
        if (cur_key + 1 >= nkeys) return a[31:0];
        b = longint'($signed(values_m[cur_key+1][c]));
        span = longint'(frames_m[cur_key+1]) - longint'(frames_m[cur_key]);
        if (span <= 0) return a[31:0];
        el = longint'(cur_frame) - longint'(frames_m[cur_key]);
        if (el < 0) el = 0;
        if (el > span) el = span;
        mag = (b >= a) ? b - a : a - b;
        q = mag * el / span;
        return (b >= a) ? 32'(a + q) : 32'(a - q);
    endfunction

    task automatic predict_pose(logic [2:0] op, logic [3:0] idx, logic [31:0] val,
                                logic [15:0] frm);
        pose_out_t r;
        r = '0;
        r.last = 1;
        if (op == kpi_pkg::OP_SAMPLE) begin
            for (int c = 0; c < kpi_pkg::NCOMP; c++) begin
                r.idx = 4'(c);
                r.value = blend_component(c);
                r.last = (c == kpi_pkg::NCOMP - 1);
                pose_q.push_back(r);
            end
            return;
        end
        case (op)
            kpi_pkg::OP_STAGE: begin
                if (idx < kpi_pkg::NCOMP) staged_m[idx] = val;
            end
            kpi_pkg::OP_APPEND: begin
                if (nkeys < MAXK) begin
                    frames_m[nkeys] = frm;
                    for (int c = 0; c < kpi_pkg::NCOMP; c++) values_m[nkeys][c] = staged_m[c];
                    nkeys++;
                end else begin
                    r.full = 1;
                end
            end
            kpi_pkg::OP_TICK: begin
                cur_frame = cur_frame + 16'd1;
                if (nkeys != 0 && cur_key + 1 < nkeys) begin
                    if (cur_frame >= frames_m[cur_key+1]) cur_key++;
                end else begin
                    nkeys = 0;
                    cur_key = 0;
                    cur_frame = 0;
                    r.done = 1;
                end
            end
            kpi_pkg::OP_CLEAR: begin
                nkeys = 0;
                cur_key = 0;
                cur_frame = 0;
            end
            default: ;
        endcase
        pose_q.push_back(r);
    endtask

    // Inputs are driven at the falling edge, well away from the sampling edge.
    task automatic send_item(logic [2:0] op, logic [3:0] idx = 0, logic [31:0] val = 0,
                             logic [15:0] frm = 0);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(negedge aclk);
        s_tuser = op;
        s_tdata = {4'b0, frm, val, idx};
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        predict_pose(op, idx, val, frm);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    always @(negedge aclk) begin
        m_tready <= !(recv_idle > 0 && $urandom_range(99) < recv_idle);
    end

    always @(posedge aclk) begin
        pose_out_t got, exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[3:0], m_tdata[35:4], m_tlast, m_tuser[0], m_tuser[1]};
            if (pose_q.size() == 0) begin
                $error("unexpected result %h", got);
                errors++;
            end else begin
                exp_r = pose_q.pop_front();
                if (got.idx !== exp_r.idx) begin
                    $error("out_index exp %0d got %0d", exp_r.idx, got.idx); errors++;
                end
                if (got.value !== exp_r.value) begin
                    $error("out_value exp %h got %h", exp_r.value, got.value); errors++;
                end
                if (got.last !== exp_r.last) begin
                    $error("out_last exp %b got %b", exp_r.last, got.last); errors++;
                end
                if (got.done !== exp_r.done) begin
                    $error("anim_done exp %b got %b", exp_r.done, got.done); errors++;
                end
                if (got.full !== exp_r.full) begin
                    $error("table_full exp %b got %b", exp_r.full, got.full); errors++;
                end
            end
        end
    end

    task automatic stage_random_key(logic [15:0] frm);
        for (int c = 0; c < kpi_pkg::NCOMP; c++)
            if ($urandom_range(3) != 0) send_item(kpi_pkg::OP_STAGE, 4'(c), $urandom());
        send_item(kpi_pkg::OP_APPEND, 0, 0, frm);
    endtask

    task automatic test_directed();
        // Empty table: zero sample and a tick that reports done.
        send_item(kpi_pkg::OP_SAMPLE);
        send_item(kpi_pkg::OP_TICK);
        send_item(kpi_pkg::OP_STAGE, 4'd15, 32'hFFFF_FFFF);
        send_item(kpi_pkg::OP_STAGE, 4'd0, 32'h7FFF_FFFF);
        send_item(kpi_pkg::OP_STAGE, 4'd14, 32'h8000_0000);
        send_item(kpi_pkg::OP_APPEND, 0, 0, 16'd0);
        send_item(kpi_pkg::OP_STAGE, 4'd0, 32'h8000_0000);
        send_item(kpi_pkg::OP_STAGE, 4'd14, 32'h7FFF_FFFF);
        send_item(kpi_pkg::OP_APPEND, 0, 0, 16'hFFFF);
        send_item(kpi_pkg::OP_SAMPLE);
        send_item(kpi_pkg::OP_TICK);
        send_item(kpi_pkg::OP_SAMPLE);
        // Non-increasing frames hold the current key.
        send_item(kpi_pkg::OP_CLEAR);
        send_item(kpi_pkg::OP_APPEND, 0, 0, 16'd5);
        send_item(kpi_pkg::OP_APPEND, 0, 0, 16'd3);
        send_item(kpi_pkg::OP_SAMPLE);
        send_item(OP_UNUSED_LO);
        send_item(OP_UNUSED_HI);
        send_item(kpi_pkg::OP_CLEAR);
    endtask

    task automatic test_full_table();
        for (int k = 0; k <= MAXK; k++) send_item(kpi_pkg::OP_APPEND, 0, 0, 16'(k * 2));
        send_item(kpi_pkg::OP_SAMPLE);
        send_item(kpi_pkg::OP_CLEAR);
    endtask

    task automatic test_random_animation(int n_items);
        int stop;
        logic [15:0] f;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            if ($urandom_range(9) == 0) begin
                send_item(3'($urandom_range(7)), 4'($urandom()), $urandom(), 16'($urandom()));
            end else begin
                f = 16'($urandom_range(3));
                for (int k = 0; k < $urandom_range(2, 4); k++) begin
                    stage_random_key(f);
                    f = ($urandom_range(7) == 0) ? 16'($urandom()) : f + 16'($urandom_range(1, 6));
                end
                for (int t = 0; t < $urandom_range(3, 8); t++) begin
                    if ($urandom_range(1)) send_item(kpi_pkg::OP_SAMPLE);
                    send_item(kpi_pkg::OP_TICK);
                end
            end
        end
        wait (pose_q.size() == 0);
    endtask

    initial begin
        nkeys = 0;
        cur_key = 0;
        cur_frame = 0;
        foreach (staged_m[i]) staged_m[i] = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        send_idle = 11; recv_idle = 64;
        test_directed();
        test_full_table();
        test_random_animation(25);
        send_idle = 64; recv_idle = 11;
        test_random_animation(25);
        send_idle = 0; recv_idle = 0;
        test_random_animation(25);
        wait (pose_q.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("tb: failure");
        $finish;
    end
endmodule
